FILE: sv/rotation_vector_to_matrix_unit_macros.svh
// assertion helpers for the rotation matrix unit
`ifndef ROTATION_VECTOR_TO_MATRIX_UNIT_MACROS_SVH
`define ROTATION_VECTOR_TO_MATRIX_UNIT_MACROS_SVH

// checked only outside reset
`define RVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define RVM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/rvm_pkg.sv
package rvm_pkg;

  localparam logic [34:0] TWO_PI_Q32  = 35'd26986075409;
  localparam logic [34:0] PI_Q32      = 35'd13493037705;
  localparam logic [34:0] HALF_PI_Q32 = 35'd6746518852;

  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam logic [31:0] LIMIT_RESET = 32'd720575940;

  localparam int TAYLOR_TERMS = 12;
  localparam int SC_LAT       = 2 * TAYLOR_TERMS + 2;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    vec_t u;
    vec_t v;
    logic negs;
    logic negc;
    logic first_order;
  } side_t;

  function automatic int unsigned sin_div(input int unsigned k);
    return 2 * k * (2 * k + 1);
  endfunction

  function automatic int unsigned cos_div(input int unsigned k);
    return (2 * k - 1) * (2 * k);
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  // shift right by 30, nearest, ties away from zero
  function automatic logic signed [67:0] rnd30(input logic signed [67:0] x);
    logic [67:0] m;
    logic [67:0] r;
    m = x[67] ? 68'(-x) : 68'(x);
    r = (m + 68'd536870912) >> 30;
    return x[67] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    if (x > 68'sd2147483647) return 32'sh7fffffff;
    if (x < -68'sd2147483648) return 32'sh80000000;
    return 32'(x);
  endfunction

endpackage

FILE: sv/rotation_vector_to_matrix_unit.sv
// throughput: one item per cycle unless out_tvalid is high and out_tready low;
// all stages advance together on one enable
// depth is set by the 32-step square root and the 31-step quotient lanes, one register
// stage per step, and the 12-term sine/cosine series, two register stages per term
// reset: synchronous active-low rst_n clears every valid bit and restores the limit
`include "rotation_vector_to_matrix_unit_macros.svh"

module rotation_vector_to_matrix_unit
  import rvm_pkg::*;
#(
  parameter int INPUT_FRAC_BITS = 28
)
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wen,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // rot_x, rot_y, rot_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [0:0]   out_tuser   // small_angle
);

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 31;
  localparam int SW        = 64 - INPUT_FRAC_BITS;
  localparam int RW        = (SW > 35) ? SW : 35;
  localparam int MOD_STEPS = SW - 34;
  localparam int SMALL_SH  = 30 - INPUT_FRAC_BITS;

  logic        ce;
  logic        out_valid_r;
  logic [31:0] limit_r;

  assign ce        = !out_valid_r || out_tready;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wen) begin
      limit_r <= cfg_wdata;
    end
  end

  // squares
  vec_t        in_vec;
  vec_t        s1_vec_r;
  logic        s1_v_r;
  logic [62:0] s1_sq_r [3];
  logic [63:0] sqx_nxt;
  logic [63:0] sqy_nxt;
  logic [63:0] sqz_nxt;

  assign in_vec.x = in_tdata[31:0];
  assign in_vec.y = in_tdata[63:32];
  assign in_vec.z = in_tdata[95:64];
  assign sqx_nxt  = 64'(abs32(in_vec.x)) * 64'(abs32(in_vec.x));
  assign sqy_nxt  = 64'(abs32(in_vec.y)) * 64'(abs32(in_vec.y));
  assign sqz_nxt  = 64'(abs32(in_vec.z)) * 64'(abs32(in_vec.z));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (ce) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_vec_r   <= in_vec;
      s1_sq_r[0] <= sqx_nxt[62:0];
      s1_sq_r[1] <= sqy_nxt[62:0];
      s1_sq_r[2] <= sqz_nxt[62:0];
    end
  end

  // squared norm and bit-serial square root
  logic [63:0] rt_x_r   [SQ_STEPS+1];
  logic [63:0] rt_res_r [SQ_STEPS+1];
  vec_t        rt_vec_r [SQ_STEPS+1];
  logic        rt_lt_r  [SQ_STEPS+1];
  logic        rt_v_r   [SQ_STEPS+1];
  logic [63:0] sq_nxt;

  assign sq_nxt = 64'(s1_sq_r[0]) + 64'(s1_sq_r[1]) + 64'(s1_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_v_r[0] <= 1'b0;
    end else if (ce) begin
      rt_v_r[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rt_x_r[0]   <= sq_nxt;
      rt_res_r[0] <= '0;
      rt_vec_r[0] <= s1_vec_r;
      rt_lt_r[0]  <= sq_nxt < {32'd0, limit_r};
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    logic        ge;
    logic [63:0] x_nxt;
    logic [63:0] res_nxt;

    assign trial   = rt_res_r[i] + BIT;
    assign ge      = rt_x_r[i] >= trial;
    assign x_nxt   = ge ? rt_x_r[i] - trial : rt_x_r[i];
    assign res_nxt = ge ? (rt_res_r[i] >> 1) + BIT : rt_res_r[i] >> 1;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_v_r[i+1] <= 1'b0;
      end else if (ce) begin
        rt_v_r[i+1] <= rt_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rt_x_r[i+1]   <= x_nxt;
        rt_res_r[i+1] <= res_nxt;
        rt_vec_r[i+1] <= rt_vec_r[i];
        rt_lt_r[i+1]  <= rt_lt_r[i];
      end
    end
  end

  // axis quotients and angle reduction
  logic [31:0]   theta;
  logic          small_nxt;
  logic [62:0]   num_nxt [3];
  logic [31:0]   vmag [3];

  logic [31:0]   dv_rem_r   [DIV_STEPS+1][3];
  logic [30:0]   dv_low_r   [DIV_STEPS+1][3];
  logic [30:0]   dv_q_r     [DIV_STEPS+1][3];
  logic [31:0]   dv_theta_r [DIV_STEPS+1];
  logic [RW-1:0] dv_ang_r   [DIV_STEPS+1];
  vec_t          dv_vec_r   [DIV_STEPS+1];
  logic          dv_small_r [DIV_STEPS+1];
  logic          dv_v_r     [DIV_STEPS+1];

  assign theta     = rt_res_r[SQ_STEPS][31:0];
  assign small_nxt = rt_lt_r[SQ_STEPS] || (theta == 32'd0);
  assign vmag[0]   = abs32(rt_vec_r[SQ_STEPS].x);
  assign vmag[1]   = abs32(rt_vec_r[SQ_STEPS].y);
  assign vmag[2]   = abs32(rt_vec_r[SQ_STEPS].z);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num_nxt[l] = {1'b0, vmag[l], 30'd0} + 63'(theta >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (ce) begin
      dv_v_r[0] <= rt_v_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int l = 0; l < 3; l++) begin
        dv_rem_r[0][l] <= num_nxt[l][62:31];
        dv_low_r[0][l] <= num_nxt[l][30:0];
        dv_q_r[0][l]   <= '0;
      end
      dv_theta_r[0] <= theta;
      dv_ang_r[0]   <= RW'(theta) << (32 - INPUT_FRAC_BITS);
      dv_vec_r[0]   <= rt_vec_r[SQ_STEPS];
      dv_small_r[0] <= small_nxt;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [32:0]   t     [3];
    logic          ge    [3];
    logic [31:0]   rem_nxt [3];
    logic [RW-1:0] ang_nxt;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        t[l]       = {dv_rem_r[j][l], dv_low_r[j][l][30]};
        ge[l]      = t[l] >= {1'b0, dv_theta_r[j]};
        rem_nxt[l] = ge[l] ? 32'(t[l] - {1'b0, dv_theta_r[j]}) : t[l][31:0];
      end
    end

    if (j < MOD_STEPS) begin : g_mod
      localparam logic [RW-1:0] MCMP = RW'(TWO_PI_Q32) << (MOD_STEPS - 1 - j);
      assign ang_nxt = (dv_ang_r[j] >= MCMP) ? dv_ang_r[j] - MCMP : dv_ang_r[j];
    end else begin : g_hold
      assign ang_nxt = dv_ang_r[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (ce) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        for (int l = 0; l < 3; l++) begin
          dv_rem_r[j+1][l] <= rem_nxt[l];
          dv_low_r[j+1][l] <= {dv_low_r[j][l][29:0], 1'b0};
          dv_q_r[j+1][l]   <= {dv_q_r[j][l][29:0], ge[l]};
        end
        dv_theta_r[j+1] <= dv_theta_r[j];
        dv_ang_r[j+1]   <= ang_nxt;
        dv_vec_r[j+1]   <= dv_vec_r[j];
        dv_small_r[j+1] <= dv_small_r[j];
      end
    end
  end

  // quadrant fold
  logic [RW-1:0] ang;
  logic          negs_nxt;
  logic          gt_nxt;
  logic [RW-1:0] r1_nxt;
  logic [RW-1:0] r2_nxt;
  logic [30:0]   a_nxt;
  side_t         side_nxt;
  vec_t          dvec;

  logic [30:0]   fd_a_r;
  side_t         fd_side_r;
  logic          fd_v_r;

  assign ang      = dv_ang_r[DIV_STEPS];
  assign dvec     = dv_vec_r[DIV_STEPS];
  assign negs_nxt = ang >= RW'(PI_Q32);
  assign r1_nxt   = negs_nxt ? ang - RW'(PI_Q32) : ang;
  assign gt_nxt   = r1_nxt > RW'(HALF_PI_Q32);
  assign r2_nxt   = gt_nxt ? RW'(PI_Q32) - r1_nxt : r1_nxt;
  assign a_nxt    = 31'((r2_nxt + RW'(2)) >> 2);

  always_comb begin
    side_nxt.u.x  = dvec.x[31] ? -$signed({1'b0, dv_q_r[DIV_STEPS][0]})
                               : $signed({1'b0, dv_q_r[DIV_STEPS][0]});
    side_nxt.u.y  = dvec.y[31] ? -$signed({1'b0, dv_q_r[DIV_STEPS][1]})
                               : $signed({1'b0, dv_q_r[DIV_STEPS][1]});
    side_nxt.u.z  = dvec.z[31] ? -$signed({1'b0, dv_q_r[DIV_STEPS][2]})
                               : $signed({1'b0, dv_q_r[DIV_STEPS][2]});
    side_nxt.v           = dvec;
    side_nxt.negs        = negs_nxt;
    side_nxt.negc        = negs_nxt ^ gt_nxt;
    side_nxt.first_order = dv_small_r[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_v_r <= 1'b0;
    end else if (ce) begin
      fd_v_r <= dv_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fd_a_r    <= a_nxt;
      fd_side_r <= side_nxt;
    end
  end

  // sine and cosine, side data in step
  logic               sc_valid;
  logic signed [33:0] sc_sin;
  logic signed [33:0] sc_cos;
  side_t              sd_r   [SC_LAT];
  logic               sd_v_r [SC_LAT];

  rvm_sincos u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (fd_v_r),
    .in_angle  (fd_a_r),
    .out_valid (sc_valid),
    .out_sin   (sc_sin),
    .out_cos   (sc_cos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SC_LAT; i++) begin
        sd_v_r[i] <= 1'b0;
      end
    end else if (ce) begin
      sd_v_r[0] <= fd_v_r;
      for (int i = 1; i < SC_LAT; i++) begin
        sd_v_r[i] <= sd_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sd_r[0] <= fd_side_r;
      for (int i = 1; i < SC_LAT; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  // matrix assembly
  side_t              sd_last;
  logic signed [33:0] sn_nxt;
  logic signed [33:0] cs_nxt;

  logic               m1_v_r;
  side_t              m1_side_r;
  logic signed [33:0] m1_sn_r;
  logic signed [33:0] m1_c1_r;
  logic signed [63:0] m1_pxx_r, m1_pyy_r, m1_pzz_r, m1_pxy_r, m1_pxz_r, m1_pyz_r;

  logic               m2_v_r;
  side_t              m2_side_r;
  logic signed [33:0] m2_sn_r;
  logic signed [33:0] m2_c1_r;
  logic signed [33:0] m2_k00_r, m2_k11_r, m2_k22_r, m2_k01_r, m2_k02_r, m2_k12_r;

  logic               m3_v_r;
  side_t              m3_side_r;
  logic signed [67:0] m3_sx_r, m3_sy_r, m3_sz_r;
  logic signed [67:0] m3_c00_r, m3_c11_r, m3_c22_r, m3_c01_r, m3_c02_r, m3_c12_r;

  assign sd_last = sd_r[SC_LAT-1];
  assign sn_nxt  = sd_last.negs ? -sc_sin : sc_sin;
  assign cs_nxt  = sd_last.negc ? -sc_cos : sc_cos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
    end else if (ce) begin
      m1_v_r <= sc_valid;
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m1_side_r <= sd_last;
      m1_sn_r   <= sn_nxt;
      m1_c1_r   <= ONE_Q30 - cs_nxt;
      m1_pxx_r  <= 64'(sd_last.u.x) * 64'(sd_last.u.x);
      m1_pyy_r  <= 64'(sd_last.u.y) * 64'(sd_last.u.y);
      m1_pzz_r  <= 64'(sd_last.u.z) * 64'(sd_last.u.z);
      m1_pxy_r  <= 64'(sd_last.u.x) * 64'(sd_last.u.y);
      m1_pxz_r  <= 64'(sd_last.u.x) * 64'(sd_last.u.z);
      m1_pyz_r  <= 64'(sd_last.u.y) * 64'(sd_last.u.z);

      m2_side_r <= m1_side_r;
      m2_sn_r   <= m1_sn_r;
      m2_c1_r   <= m1_c1_r;
      m2_k00_r  <= 34'(rnd30(-(68'(m1_pyy_r) + 68'(m1_pzz_r))));
      m2_k11_r  <= 34'(rnd30(-(68'(m1_pxx_r) + 68'(m1_pzz_r))));
      m2_k22_r  <= 34'(rnd30(-(68'(m1_pxx_r) + 68'(m1_pyy_r))));
      m2_k01_r  <= 34'(rnd30(68'(m1_pxy_r)));
      m2_k02_r  <= 34'(rnd30(68'(m1_pxz_r)));
      m2_k12_r  <= 34'(rnd30(68'(m1_pyz_r)));

      m3_side_r <= m2_side_r;
      m3_sx_r   <= 68'(m2_sn_r) * 68'(m2_side_r.u.x);
      m3_sy_r   <= 68'(m2_sn_r) * 68'(m2_side_r.u.y);
      m3_sz_r   <= 68'(m2_sn_r) * 68'(m2_side_r.u.z);
      m3_c00_r  <= 68'(m2_c1_r) * 68'(m2_k00_r);
      m3_c11_r  <= 68'(m2_c1_r) * 68'(m2_k11_r);
      m3_c22_r  <= 68'(m2_c1_r) * 68'(m2_k22_r);
      m3_c01_r  <= 68'(m2_c1_r) * 68'(m2_k01_r);
      m3_c02_r  <= 68'(m2_c1_r) * 68'(m2_k02_r);
      m3_c12_r  <= 68'(m2_c1_r) * 68'(m2_k12_r);
    end
  end

  logic signed [67:0] s_x, s_y, s_z;
  logic signed [67:0] c_00, c_11, c_22, c_01, c_02, c_12;
  logic signed [67:0] w_x, w_y, w_z;
  logic signed [67:0] one_w;
  logic signed [31:0] m_nxt [9];
  logic signed [31:0] out_m_r [9];
  logic               out_small_r;

  assign s_x   = rnd30(m3_sx_r);
  assign s_y   = rnd30(m3_sy_r);
  assign s_z   = rnd30(m3_sz_r);
  assign c_00  = rnd30(m3_c00_r);
  assign c_11  = rnd30(m3_c11_r);
  assign c_22  = rnd30(m3_c22_r);
  assign c_01  = rnd30(m3_c01_r);
  assign c_02  = rnd30(m3_c02_r);
  assign c_12  = rnd30(m3_c12_r);
  assign w_x   = 68'(m3_side_r.v.x) <<< SMALL_SH;
  assign w_y   = 68'(m3_side_r.v.y) <<< SMALL_SH;
  assign w_z   = 68'(m3_side_r.v.z) <<< SMALL_SH;
  assign one_w = 68'(ONE_Q30);

  always_comb begin
    if (m3_side_r.first_order) begin
      m_nxt[0] = 32'(ONE_Q30);
      m_nxt[1] = sat32(-w_z);
      m_nxt[2] = sat32(w_y);
      m_nxt[3] = sat32(w_z);
      m_nxt[4] = 32'(ONE_Q30);
      m_nxt[5] = sat32(-w_x);
      m_nxt[6] = sat32(-w_y);
      m_nxt[7] = sat32(w_x);
      m_nxt[8] = 32'(ONE_Q30);
    end else begin
      m_nxt[0] = sat32(one_w + c_00);
      m_nxt[1] = sat32(c_01 - s_z);
      m_nxt[2] = sat32(c_02 + s_y);
      m_nxt[3] = sat32(c_01 + s_z);
      m_nxt[4] = sat32(one_w + c_11);
      m_nxt[5] = sat32(c_12 - s_x);
      m_nxt[6] = sat32(c_02 - s_y);
      m_nxt[7] = sat32(c_12 + s_x);
      m_nxt[8] = sat32(one_w + c_22);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= m3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_m_r     <= m_nxt;
      out_small_r <= m3_side_r.first_order;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_small_r;
  assign out_tdata  = {out_m_r[8], out_m_r[7], out_m_r[6], out_m_r[5], out_m_r[4],
                       out_m_r[3], out_m_r[2], out_m_r[1], out_m_r[0]};

  `RVM_ASSERT(a_side_align, sc_valid == sd_v_r[SC_LAT-1], "side data out of step with sin/cos")
  `RVM_ASSERT(a_small_diag, out_tvalid && out_tuser[0] |-> out_tdata[31:0] == 32'h40000000 && out_tdata[159:128] == 32'h40000000 && out_tdata[287:256] == 32'h40000000, "small-angle result lacks unit diagonal")
  `RVM_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule

FILE: sv/rvm_sincos.sv
module rvm_sincos
  import rvm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ce,
  input  logic               in_valid,
  input  logic [30:0]        in_angle,
  output logic               out_valid,
  output logic signed [33:0] out_sin,
  output logic signed [33:0] out_cos
);

  localparam int T = TAYLOR_TERMS;
  localparam logic [31:0] ONE_T = 32'd1073741824;

  logic        v0_r;
  logic [30:0] a0_r;
  logic [61:0] aa_r;
  logic [31:0] x2_nxt;

  logic               vb_r  [T];
  logic               vc_r  [T];
  logic [31:0]        x2b_r [T];
  logic [31:0]        x2c_r [T];
  logic [63:0]        pms_r [T];
  logic [63:0]        pmc_r [T];
  logic signed [33:0] ssb_r [T];
  logic signed [33:0] csb_r [T];
  logic signed [33:0] ssc_r [T];
  logic signed [33:0] csc_r [T];
  logic [65:0]        qs_r  [T];
  logic [65:0]        qc_r  [T];

  logic               vo_r;
  logic signed [33:0] sin_r;
  logic signed [33:0] cos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (ce) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a0_r <= in_angle;
      aa_r <= 62'(in_angle) * 62'(in_angle);
    end
  end

  assign x2_nxt = 32'((aa_r + 62'd536870912) >> 30);

  for (genvar k = 0; k < T; k++) begin : g_term
    localparam int unsigned DS = sin_div(k + 1);
    localparam int unsigned DC = cos_div(k + 1);
    localparam int unsigned LS = $clog2(DS);
    localparam int unsigned LC = $clog2(DC);
    localparam logic [65:0] MS = ((66'd1 << (32 + LS)) + 66'(DS) - 66'd1) / 66'(DS);
    localparam logic [65:0] MC = ((66'd1 << (32 + LC)) + 66'(DC) - 66'd1) / 66'(DC);
    localparam logic [31:0] HS = 32'(DS / 2);
    localparam logic [31:0] HC = 32'(DC / 2);

    logic [31:0]        ts_prev;
    logic [31:0]        tc_prev;
    logic [31:0]        x2_in;
    logic signed [33:0] ss_in;
    logic signed [33:0] cs_in;
    logic               v_in;
    logic [31:0]        ns_nxt;
    logic [31:0]        nc_nxt;

    if (k == 0) begin : g_first
      assign ts_prev = {1'b0, a0_r};
      assign tc_prev = ONE_T;
      assign ss_in   = $signed({3'b000, a0_r});
      assign cs_in   = ONE_Q30;
      assign x2_in   = x2_nxt;
      assign v_in    = v0_r;
    end else begin : g_next
      localparam int unsigned LSP = $clog2(sin_div(k));
      localparam int unsigned LCP = $clog2(cos_div(k));
      localparam bit SUB = (k % 2) == 1;
      assign ts_prev = 32'(qs_r[k-1] >> (32 + LSP));
      assign tc_prev = 32'(qc_r[k-1] >> (32 + LCP));
      assign ss_in   = SUB ? ssc_r[k-1] - $signed({2'b00, ts_prev})
                           : ssc_r[k-1] + $signed({2'b00, ts_prev});
      assign cs_in   = SUB ? csc_r[k-1] - $signed({2'b00, tc_prev})
                           : csc_r[k-1] + $signed({2'b00, tc_prev});
      assign x2_in   = x2c_r[k-1];
      assign v_in    = vc_r[k-1];
    end

    assign ns_nxt = 32'((pms_r[k] + 64'd536870912) >> 30) + HS;
    assign nc_nxt = 32'((pmc_r[k] + 64'd536870912) >> 30) + HC;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vb_r[k] <= 1'b0;
        vc_r[k] <= 1'b0;
      end else if (ce) begin
        vb_r[k] <= v_in;
        vc_r[k] <= vb_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        x2b_r[k] <= x2_in;
        pms_r[k] <= 64'(ts_prev) * 64'(x2_in);
        pmc_r[k] <= 64'(tc_prev) * 64'(x2_in);
        ssb_r[k] <= ss_in;
        csb_r[k] <= cs_in;
        x2c_r[k] <= x2b_r[k];
        ssc_r[k] <= ssb_r[k];
        csc_r[k] <= csb_r[k];
        qs_r[k]  <= 66'(ns_nxt) * MS;
        qc_r[k]  <= 66'(nc_nxt) * MC;
      end
    end
  end

  localparam int unsigned LSL = $clog2(sin_div(T));
  localparam int unsigned LCL = $clog2(cos_div(T));
  localparam bit SUBL = (T % 2) == 1;

  logic [31:0]        ts_last;
  logic [31:0]        tc_last;
  logic signed [33:0] sin_nxt;
  logic signed [33:0] cos_nxt;

  assign ts_last = 32'(qs_r[T-1] >> (32 + LSL));
  assign tc_last = 32'(qc_r[T-1] >> (32 + LCL));
  assign sin_nxt = SUBL ? ssc_r[T-1] - $signed({2'b00, ts_last})
                        : ssc_r[T-1] + $signed({2'b00, ts_last});
  assign cos_nxt = SUBL ? csc_r[T-1] - $signed({2'b00, tc_last})
                        : csc_r[T-1] + $signed({2'b00, tc_last});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (ce) begin
      vo_r <= vc_r[T-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_sin   = sin_r;
  assign out_cos   = cos_r;

endmodule
